@@ rtl/spq_pkg.sv @@
// Shared types, codes and sizes for the sorted priority queue.
package spq_pkg;

  // Table geometry
  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Request codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LIST   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        name_tag;
    logic signed [15:0] priority_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        out_tag;
    logic signed [15:0] out_priority;
    logic               last;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       do_insert;
    logic       sweep_step;
    logic       sweep_commit;
    logic       list_step;
    logic       emit;
    logic       emit_entry;
    logic [1:0] status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic sweep_done;
    logic list_last;
    logic found;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/spq_ctrl.sv @@
// Sequencer for insert, delete sweep and list readout.
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_action_i,
  output logic          in_stall_o,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_DEL  = 2'd2;
  localparam logic [1:0] S_LIST = 2'd3;

  logic [1:0] state_q, state_d;

  // Request port is open only between requests
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          case (in_action_i)
            spq_pkg::ACT_INSERT: state_d = S_INS;
            spq_pkg::ACT_DELETE: state_d = S_DEL;
            spq_pkg::ACT_LIST:   state_d = S_LIST;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.do_insert = !sts_i.full;
          cmd_o.status    = sts_i.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
          state_d         = S_IDLE;
        end
      end
      S_DEL: begin
        if (!sts_i.sweep_done) begin
          cmd_o.sweep_step = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.sweep_commit = 1'b1;
          cmd_o.status       = sts_i.found ? spq_pkg::ST_OK : spq_pkg::ST_NOTFOUND;
          state_d            = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.empty) begin
            cmd_o.status = spq_pkg::ST_EMPTY;
            state_d      = S_IDLE;
          end else begin
            cmd_o.status     = spq_pkg::ST_OK;
            cmd_o.emit_entry = 1'b1;
            cmd_o.list_step  = 1'b1;
            if (sts_i.list_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/spq_datapath.sv @@
// Entry table, sweep pointers and result register.
module spq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::in_beat_t in_beat_i,
  input  spq_pkg::cmd_t     cmd_i,
  output spq_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::out_beat_t out_beat_o
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int IDX_W = spq_pkg::IDX_W;
  localparam int CNT_W = spq_pkg::CNT_W;
  localparam int TAG_W = spq_pkg::TAG_BITS;

  // Table storage, contents beyond the fill count are don't-care
  logic [TAG_W-1:0]   tag_q  [DEPTH];
  logic signed [15:0] prio_q [DEPTH];
  logic [CNT_W-1:0]   count_q;

  // Latched request
  logic [TAG_W-1:0]   req_tag_q;
  logic signed [15:0] req_prio_q;

  // Sweep read/write pointers; rd doubles as the list index
  logic [CNT_W-1:0]   rd_q;
  logic [CNT_W-1:0]   wr_q;
  logic               found_q;

  logic               out_valid_q;
  spq_pkg::out_beat_t out_beat_q;

  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   take_new;
  logic [TAG_W-1:0]   rd_tag;
  logic signed [15:0] rd_prio;
  logic               rd_match;

  // Entries that stay ahead of the new one form a prefix of the table
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count_q) && (prio_q[i] > req_prio_q);
    end
    take_new[0] = !gt[0];
    for (int i = 1; i < DEPTH; i++) begin
      take_new[i] = !gt[i] && gt[i-1];
    end
  end

  // Single read port at the sweep pointer
  assign rd_tag   = tag_q[rd_q[IDX_W-1:0]];
  assign rd_prio  = prio_q[rd_q[IDX_W-1:0]];
  assign rd_match = (rd_tag == req_tag_q);

  // Table update: shifted insert of the whole table at once, or one compaction step
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_insert) begin
      if (take_new[0]) begin
        tag_q[0]  <= req_tag_q;
        prio_q[0] <= req_prio_q;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (take_new[i]) begin
          tag_q[i]  <= req_tag_q;
          prio_q[i] <= req_prio_q;
        end else if (!gt[i]) begin
          tag_q[i]  <= tag_q[i-1];
          prio_q[i] <= prio_q[i-1];
        end
      end
    end else if (cmd_i.sweep_step && !rd_match) begin
      tag_q[wr_q[IDX_W-1:0]]  <= rd_tag;
      prio_q[wr_q[IDX_W-1:0]] <= rd_prio;
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_tag_q  <= TAG_W'(in_beat_i.name_tag);
      req_prio_q <= in_beat_i.priority_req;
    end
  end

  // Fill count and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        rd_q    <= '0;
        wr_q    <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.sweep_step || cmd_i.list_step) begin
          rd_q <= rd_q + CNT_W'(1);
        end
        if (cmd_i.sweep_step) begin
          if (rd_match) begin
            found_q <= 1'b1;
          end else begin
            wr_q <= wr_q + CNT_W'(1);
          end
        end
      end
      if (cmd_i.do_insert) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.sweep_commit) begin
        count_q <= wr_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_beat_q.status <= cmd_i.status;
      if (cmd_i.emit_entry) begin
        out_beat_q.out_tag      <= 32'(rd_tag);
        out_beat_q.out_priority <= rd_prio;
        out_beat_q.last         <= sts_o.list_last;
      end else begin
        out_beat_q.out_tag      <= '0;
        out_beat_q.out_priority <= '0;
        out_beat_q.last         <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Status back to the controller
  assign sts_o.full       = (count_q == CNT_W'(DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.sweep_done = (rd_q == count_q);
  assign sts_o.list_last  = (rd_q + CNT_W'(1) == count_q);
  assign sts_o.found      = found_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue.
//
//  channel | dir | beat type            | handshake
//  --------+-----+----------------------+----------------------------------
//  request | in  | spq_pkg::in_beat_t   | in_valid_i / in_stall_o
//  result  | out | spq_pkg::out_beat_t  | out_valid_o / out_stall_i
//
//  Insert: accept, then shifted write of the whole table at once.
//  Delete: accept, then the compaction sweep, one entry a cycle, then the commit.
//  List: one result beat a cycle while results are not stalled (a lone beat when empty).
//  One request is in work at a time; the next is taken while the last result
//  beat waits in the output register. Result stalls hold the sequencer.
//  Reset empties the table at once; no clearing pass.
module sorted_priority_queue_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_beat_t out_beat_o
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_beat_i.action),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

@@ rtl/spq_chk.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input spq_pkg::in_beat_t  in_beat_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input spq_pkg::out_beat_t out_beat_o
);

  // A stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("result payload changed while stalled");

  // An accepted insert keeps the request port closed for its execution cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_beat_i.action == spq_pkg::ACT_INSERT |=> in_stall_o)
    else $error("request taken during insert");

  // Any status other than ok is a lone, final beat with no entry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status != spq_pkg::ST_OK |->
      out_beat_o.last && out_beat_o.out_tag == '0 && out_beat_o.out_priority == '0)
    else $error("error status beat carries data or is not last");

endmodule

bind sorted_priority_queue_core spq_chk u_spq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

@@ tb/tb_sorted_priority_queue_core.sv @@
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;

  localparam logic [1:0] ACT_IGNORED = 2'd3;  // undefined code, block drops it
  localparam int         STALL_LIMIT = 4000;  // cycles without any beat moving
  localparam int         TAIL_CYCLES = 2 * spq_pkg::DEPTH + 8;
  localparam int         PHASE_ITEMS = 40;

  // Table mirror and queue of result beats still owed by the block
  class spq_scoreboard;
    logic [31:0]        tags  [spq_pkg::DEPTH];
    logic signed [15:0] prios [spq_pkg::DEPTH];
    int                 fill;
    spq_pkg::out_beat_t owed_q [$];
    int                 n_err, n_beats, n_full, n_hits, n_lists;

    function new();
      fill = 0;
      n_err = 0;
      n_beats = 0;
      n_full = 0;
      n_hits = 0;
      n_lists = 0;
    endfunction

    // Apply an accepted request to the mirror and queue the beats it owes
    function void note_request(spq_pkg::in_beat_t b);
      spq_pkg::out_beat_t r;
      logic signed [15:0] p;
      int                 pos;
      int                 wr;
      bit                 hit;
      r      = '0;
      r.last = 1'b1;
      p      = b.priority_req;
      case (b.action)
        spq_pkg::ACT_INSERT: begin
          if (fill >= spq_pkg::DEPTH) begin
            r.status = spq_pkg::ST_FULL;
            n_full++;
          end else begin
            // new entry goes ahead of the first one not strictly higher
            pos = 0;
            while (pos < fill && prios[pos] > p) pos++;
            for (int i = fill; i > pos; i--) begin
              tags[i]  = tags[i-1];
              prios[i] = prios[i-1];
            end
            tags[pos]  = b.name_tag;
            prios[pos] = p;
            fill++;
            r.status = spq_pkg::ST_OK;
          end
          owed_q.push_back(r);
        end
        spq_pkg::ACT_DELETE: begin
          // drop every match and close the gaps
          wr  = 0;
          hit = 1'b0;
          for (int i = 0; i < fill; i++) begin
            if (tags[i] == b.name_tag) begin
              hit = 1'b1;
            end else begin
              tags[wr]  = tags[i];
              prios[wr] = prios[i];
              wr++;
            end
          end
          fill = wr;
          r.status = hit ? spq_pkg::ST_OK : spq_pkg::ST_NOTFOUND;
          if (hit) n_hits++;
          owed_q.push_back(r);
        end
        spq_pkg::ACT_LIST: begin
          n_lists++;
          if (fill == 0) begin
            r.status = spq_pkg::ST_EMPTY;
            owed_q.push_back(r);
          end else begin
            for (int i = 0; i < fill; i++) begin
              r.status       = spq_pkg::ST_OK;
              r.out_tag      = tags[i];
              r.out_priority = prios[i];
              r.last         = (i == fill - 1);
              owed_q.push_back(r);
            end
          end
        end
        default: ;  // ignored code: no beat, no change
      endcase
    endfunction

    function void flag(string what, spq_pkg::out_beat_t want, spq_pkg::out_beat_t got);
      n_err++;
      if (n_err <= 10)
        $display("%0t %s: want st=%0d tag=%h pri=%0d last=%b, got st=%0d tag=%h pri=%0d %s%b",
                 $realtime, what, want.status, want.out_tag, $signed(want.out_priority),
                 want.last, got.status, got.out_tag, $signed(got.out_priority),
                 "last=", got.last);
    endfunction

    // Compare an accepted result beat with the oldest one owed
    function void check_result(spq_pkg::out_beat_t got);
      spq_pkg::out_beat_t want;
      n_beats++;
      if (owed_q.size() == 0) begin
        flag("unexpected result beat", 'x, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status || got.out_tag !== want.out_tag ||
          got.out_priority !== want.out_priority || got.last !== want.last)
        flag("result mismatch", want, got);
    endfunction
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  spq_pkg::in_beat_t  in_beat   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  spq_pkg::out_beat_t out_beat;

  spq_scoreboard sb = new();

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;
  int          n_items = 0;
  int          idle_run = 0;
  logic [31:0] tag_pool [6];

  sorted_priority_queue_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check accepted beats, then choose next cycle's stall
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_beat);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
    else idle_run++;
    if (idle_run >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic spq_pkg::in_beat_t mk(logic [1:0] act, logic [31:0] tag,
                                           logic [15:0] pri);
    spq_pkg::in_beat_t b;
    b.action       = act;
    b.name_tag     = tag;
    b.priority_req = pri;
    return b;
  endfunction

  function automatic logic [31:0] rand_tag();
    if ($urandom_range(99) < 60) return tag_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  // Corner values and a narrow band for ties, otherwise anything
  function automatic logic [15:0] rand_prio();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      case ($urandom_range(4))
        0: return 16'sh8000;
        1: return 16'shFFFF;
        2: return 16'sh0000;
        3: return 16'sh0001;
        default: return 16'sh7FFF;
      endcase
    end
    if (r < 65) return 16'($urandom_range(6)) - 16'd3;
    return 16'($urandom);
  endfunction

  // Offer one request beat and hold it until the block takes it
  task automatic send_req(spq_pkg::in_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b);
    if (b.action != ACT_IGNORED) n_items++;
  endtask

  // Sender pauses until every owed result beat has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  // Fill to capacity, knock on a full table, then read it back
  task automatic fill_burst();
    while (sb.fill < spq_pkg::DEPTH)
      send_req(mk(spq_pkg::ACT_INSERT, rand_tag(), rand_prio()));
    repeat ($urandom_range(1, 2))
      send_req(mk(spq_pkg::ACT_INSERT, rand_tag(), rand_prio()));
    send_req(mk(spq_pkg::ACT_LIST, $urandom, 16'($urandom)));
  endtask

  // Remove stored tags one by one, then read back what is left
  task automatic drain_burst();
    int n;
    n = $urandom_range(2, 8);
    while (n > 0 && sb.fill > 0) begin
      send_req(mk(spq_pkg::ACT_DELETE, sb.tags[$urandom_range(sb.fill - 1)],
                  16'($urandom)));
      n--;
    end
    send_req(mk(spq_pkg::ACT_LIST, $urandom, 16'($urandom)));
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      fill_burst();
    end else if (r < 14) begin
      drain_burst();
    end else begin
      r = $urandom_range(99);
      if (r < 45)
        send_req(mk(spq_pkg::ACT_INSERT, rand_tag(), rand_prio()));
      else if (r < 70)
        send_req(mk(spq_pkg::ACT_DELETE, (sb.fill > 0 && $urandom_range(1)) ?
                    sb.tags[$urandom_range(sb.fill - 1)] : rand_tag(), 16'($urandom)));
      else if (r < 94)
        send_req(mk(spq_pkg::ACT_LIST, $urandom, 16'($urandom)));
      else
        send_req(mk(ACT_IGNORED, $urandom, 16'($urandom)));
    end
  endtask

  // Main sequence
  initial begin
    int tx_pct [4];
    int rx_pct [4];
    int goal;
    tx_pct = '{0, 76, 0, 9};
    rx_pct = '{0, 0, 76, 9};
    tag_pool[0] = 32'h0000_0000;
    tag_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) tag_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, ties, duplicate tags, extremes, removal to empty
    send_req(mk(spq_pkg::ACT_LIST,   32'h0,         16'sh0));
    send_req(mk(spq_pkg::ACT_DELETE, 32'hDEAD_BEEF, 16'sh0));
    send_req(mk(ACT_IGNORED,         32'hFFFF_FFFF, 16'shFFFF));
    send_req(mk(spq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'sh7FFF));
    send_req(mk(spq_pkg::ACT_INSERT, 32'h0000_0000, 16'sh8000));
    send_req(mk(spq_pkg::ACT_INSERT, 32'hA5A5_A5A5, 16'sh0000));
    send_req(mk(spq_pkg::ACT_INSERT, 32'h5A5A_5A5A, 16'sh0000));
    send_req(mk(spq_pkg::ACT_INSERT, 32'h0000_0001, 16'sh7FFF));
    send_req(mk(spq_pkg::ACT_INSERT, 32'hA5A5_A5A5, 16'shFFFF));
    send_req(mk(spq_pkg::ACT_LIST,   32'h0,         16'sh0));
    send_req(mk(spq_pkg::ACT_DELETE, 32'hA5A5_A5A5, 16'sh0));
    send_req(mk(spq_pkg::ACT_DELETE, 32'h1234_5678, 16'sh0));
    send_req(mk(spq_pkg::ACT_LIST,   32'hFFFF_FFFF, 16'shFFFF));
    send_req(mk(spq_pkg::ACT_DELETE, 32'hFFFF_FFFF, 16'sh0));
    send_req(mk(spq_pkg::ACT_DELETE, 32'h0000_0000, 16'sh0));
    send_req(mk(spq_pkg::ACT_DELETE, 32'h5A5A_5A5A, 16'sh0));
    send_req(mk(spq_pkg::ACT_DELETE, 32'h0000_0001, 16'sh0));
    send_req(mk(spq_pkg::ACT_LIST,   32'h0,         16'sh0));
    send_req(mk(spq_pkg::ACT_DELETE, 32'h0000_0001, 16'sh0));
    wait_drained();

    // Random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      goal = n_items + PHASE_ITEMS;
      if (ph == 0) begin
        // long result hold-off while requests keep coming: block backs up
        fill_burst();
        hold_left = 200;
        repeat (4) send_req(mk(spq_pkg::ACT_LIST, $urandom, 16'($urandom)));
        repeat (4) send_req(mk(spq_pkg::ACT_INSERT, rand_tag(), rand_prio()));
      end
      while (n_items < goal) random_step();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d result beats (%0d lists), %0d full rejections,",
             n_items, sb.n_beats, sb.n_lists, sb.n_full);
    $display("%0d matching deletes; %0d mismatches", sb.n_hits, sb.n_err);
    if (sb.n_err == 0 && sb.owed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
